// ===== rtl/rle2_pkg.sv =====
// Package: shared types, constants and the palette color lookup for the RLE image decoder.
package rle2_pkg;

   localparam int HEADER_BYTES = 3;
   localparam int RUN_WIDTH    = 16;

   localparam logic [5:0] RUN_EXTEND_LEN = 6'h3f;
   localparam logic [7:0] EXTEND_MORE    = 8'hff;

   localparam int CUBE_STEP  = 'h33;
   localparam int CUBE_SIZE  = 216;
   localparam int GRAY_START = 252;
   localparam int TINT_BASE  = 'h7f;
   localparam int TINT_GREEN = 'h4c;
   localparam int GRAY_BASE  = 'h2c;
   localparam int GRAY_STEP  = 'h10;
   localparam int MASK_GREEN = 'h07e0;
   localparam int MASK_RED   = 'hf800;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_EXTEND  = 2'd1,
      MODE_PALETTE = 2'd2
   } mode_type;

   typedef logic [3:0][15:0]   palette_type;
   typedef logic [255:0][15:0] cube_lut_type;

   localparam palette_type PALETTE_RESET = {16'hffff, 16'h7bef, 16'h4a69, 16'h0000};

   typedef struct packed {
      logic        emit;
      logic [15:0] color;
      logic [15:0] length;
   } result_type;

   // 6x6x6 color cube, then a 3x4x3 tinted block, then four grays
   function automatic cube_lut_type build_cube_lut();
      cube_lut_type lut;
      int c;
      int q;
      int w;
      int g6;
      int g5;
      for (int v = 0; v < 256; v++) begin
         if (v < CUBE_SIZE) begin
            c = ((v % 6) * CUBE_STEP) >> 3;
            q = v / 6;
            c += ((q % 6) * (CUBE_STEP << 3)) & MASK_GREEN;
            c += ((q / 6) * (CUBE_STEP << 8)) & MASK_RED;
         end else if (v < GRAY_START) begin
            w = v - CUBE_SIZE;
            c = (TINT_BASE + (w % 3) * CUBE_STEP) >> 3;
            q = w / 3;
            c += ((TINT_GREEN << 3) + (q % 4) * (CUBE_STEP << 3)) & MASK_GREEN;
            c += ((TINT_BASE << 8) + (q / 4) * (CUBE_STEP << 8)) & MASK_RED;
         end else begin
            w  = v - GRAY_START;
            g6 = (GRAY_BASE + GRAY_STEP * w) >> 2;
            g5 = g6 >> 1;
            c  = (g5 << 11) + (g6 << 5) + g5;
         end
         lut[v] = c[15:0];
      end
      return lut;
   endfunction

   localparam cube_lut_type CUBE_LUT = build_cube_lut();

endpackage

// ===== rtl/rle2_core.sv =====
// Decoder state and per-byte run/palette decode.
module rle2_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          code_byte,
   input  logic                image_start,
   output rle2_pkg::result_type result
);
   import rle2_pkg::*;

   mode_type               mode_ff, mode_in, mode_cur;
   logic [RUN_WIDTH-1:0]   run_ff, run_in, run_cur, run_emit;
   logic [1:0]             index_ff, index_in, index_cur;
   logic [1:0]             slot_ff, slot_in, slot_cur;
   logic [1:0]             hdr_ff, hdr_in, hdr_cur;
   logic [3:1][15:0]       color_ff, color_in;
   palette_type            color_cur;
   logic [RUN_WIDTH:0]     run_sum;
   logic [RUN_WIDTH-1:0]   run_sat;
   logic [31:0]            len_wide;
   logic [15:0]            pick;

   always_comb begin
      // image start restores everything before the byte itself is looked at
      if (image_start) begin
         mode_cur  = MODE_IDLE;
         run_cur   = '0;
         index_cur = 2'd0;
         slot_cur  = 2'd1;
         hdr_cur   = 2'(HEADER_BYTES);
         color_cur = PALETTE_RESET;
      end else begin
         mode_cur  = mode_ff;
         run_cur   = run_ff;
         index_cur = index_ff;
         slot_cur  = slot_ff;
         hdr_cur   = hdr_ff;
         color_cur = {color_ff, 16'h0000};
      end

      run_sum = {1'b0, run_cur} + (RUN_WIDTH+1)'(code_byte);
      run_sat = run_sum[RUN_WIDTH] ? '1 : run_sum[RUN_WIDTH-1:0];

      mode_in   = mode_cur;
      run_in    = run_cur;
      index_in  = index_cur;
      slot_in   = slot_cur;
      hdr_in    = hdr_cur;
      color_in  = color_cur[3:1];
      run_emit  = '0;
      result.emit = 1'b0;

      if (hdr_cur != 2'd0) begin
         hdr_in = hdr_cur - 2'd1;
      end else begin
         unique case (mode_cur)
            MODE_PALETTE: begin
               for (int i = 1; i < 4; i++) begin
                  if (slot_cur == 2'(i)) color_in[i] = CUBE_LUT[code_byte];
               end
               slot_in = (slot_cur == 2'd3 || slot_cur == 2'd0) ? 2'd1 : slot_cur + 2'd1;
               mode_in = MODE_IDLE;
            end
            MODE_EXTEND: begin
               if (code_byte == EXTEND_MORE) begin
                  run_in = run_sat;
               end else begin
                  run_emit    = run_sat;
                  result.emit = 1'b1;
                  run_in      = '0;
                  mode_in     = MODE_IDLE;
               end
            end
            default: begin
               index_in = code_byte[7:6];
               run_in   = RUN_WIDTH'(code_byte[5:0]);
               if (code_byte[5:0] == 6'd0) begin
                  mode_in = MODE_PALETTE;
               end else if (code_byte[5:0] == RUN_EXTEND_LEN) begin
                  mode_in = MODE_EXTEND;
               end else begin
                  run_emit    = RUN_WIDTH'(code_byte[5:0]);
                  result.emit = 1'b1;
                  run_in      = '0;
                  mode_in     = MODE_IDLE;
               end
            end
         endcase
      end

      pick          = color_cur[index_in];
      result.color  = {pick[7:0], pick[15:8]};
      len_wide      = 32'(run_emit);
      result.length = (len_wide > 32'h0000_ffff) ? 16'hffff : len_wide[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         run_ff   <= '0;
         index_ff <= 2'd0;
         slot_ff  <= 2'd1;
         hdr_ff   <= 2'd0;
         color_ff <= PALETTE_RESET[3:1];
      end else if (step) begin
         mode_ff  <= mode_in;
         run_ff   <= run_in;
         index_ff <= index_in;
         slot_ff  <= slot_in;
         hdr_ff   <= hdr_in;
         color_ff <= color_in;
      end
   end

endmodule

// ===== rtl/rle2bit_palette_image_decoder.sv =====
// Top level: two-bit run-length image decoder with byte-swapped RGB565 palette output.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | req_code_byte, req_image_start
//  rsp     | out       | rsp_valid / rsp_stall | rsp_pixel_color, rsp_run_length
//
// One byte per cycle while req_stall is low; a run result passes through
// the input register, decode and the result register.
// Synchronous reset restores the default palette and idle decode state.
// A stalled result holds; the input register keeps accepting until it holds
// an undecoded byte behind a stalled result, then req_stall rises.
module rle2bit_palette_image_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_code_byte,
   input  logic        req_image_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_pixel_color,
   output logic [15:0] rsp_run_length
);
   import rle2_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;
   logic        out_valid_ff;
   logic [15:0] out_color_ff;
   logic [15:0] out_len_ff;
   logic        advance;
   logic        step;
   result_type  result;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   rle2_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .code_byte   (in_byte_ff),
      .image_start (in_start_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) in_valid_ff <= req_valid;
         if (advance) out_valid_ff <= step && result.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff  <= req_code_byte;
         in_start_ff <= req_image_start;
      end
      if (step && result.emit) begin
         out_color_ff <= result.color;
         out_len_ff   <= result.length;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_run_length  = out_len_ff;

`ifndef SYNTH
   // back-pressure on requests only comes from a stalled result
   a_stall_cause: assert property (@(posedge clock) req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled result");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_run_length != 16'd0))
      else $error("run result with zero length");

   a_reset_quiet: assert property (@(posedge clock) reset |=> (!rsp_valid && !req_stall))
      else $error("activity right after reset");

   // a taken result with no new decode leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !in_valid_ff) |=> !rsp_valid)
      else $error("result repeated");
`endif

endmodule

// ===== verif/rle2_run_checker.sv =====
// Run checker: predicts decoded runs from accepted requests and compares them with results.
`timescale 1ns / 100ps

module rle2_run_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_code_byte,
   input  logic        req_image_start,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_pixel_color,
   input  logic [15:0] rsp_run_length,
   output int          error_count,
   output int          pending_runs
);
   import rle2_pkg::*;

   localparam longint RUN_LIMIT = (longint'(1) << RUN_WIDTH) - 1;

   typedef struct packed {
      logic [15:0] color;
      logic [15:0] length;
   } pixel_run_type;

   pixel_run_type expected_runs[$];

   // decoder state as predicted
   longint      run_total;
   mode_type    mode;
   logic [1:0]  run_index;
   logic [15:0] shades [4];
   logic [1:0]  next_slot;
   int          header_skip;
   int          errors;

   function automatic logic [15:0] index_to_rgb565(input logic [7:0] index);
      int v;
      int c;
      int q;
      int g6;
      int g5;
      v = int'(index);
      if (v < CUBE_SIZE) begin
         c = ((v % 6) * CUBE_STEP) >> 3;
         q = v / 6;
         c += ((q % 6) * (CUBE_STEP << 3)) & MASK_GREEN;
         c += ((q / 6) * (CUBE_STEP << 8)) & MASK_RED;
      end else if (v < GRAY_START) begin
         v -= CUBE_SIZE;
         c = (TINT_BASE + (v % 3) * CUBE_STEP) >> 3;
         q = v / 3;
         c += ((TINT_GREEN << 3) + (q % 4) * (CUBE_STEP << 3)) & MASK_GREEN;
         c += ((TINT_BASE << 8) + (q / 4) * (CUBE_STEP << 8)) & MASK_RED;
      end else begin
         v -= GRAY_START;
         g6 = (GRAY_BASE + GRAY_STEP * v) >> 2;
         g5 = g6 >> 1;
         c = (g5 << 11) + (g6 << 5) + g5;
      end
      return c[15:0];
   endfunction

   task automatic restore_defaults();
      run_total = 0;
      mode = MODE_IDLE;
      run_index = 2'd0;
      shades[0] = 16'h0000;
      shades[1] = 16'h4a69;
      shades[2] = 16'h7bef;
      shades[3] = 16'hffff;
      next_slot = 2'd1;
      header_skip = 0;
   endtask

   task automatic grow_run(input longint n);
      run_total += n;
      if (run_total > RUN_LIMIT) run_total = RUN_LIMIT;
   endtask

   task automatic decode_code(input logic [7:0] code, input logic start);
      logic [15:0]   shade;
      pixel_run_type run;
      if (start) begin
         restore_defaults();
         header_skip = HEADER_BYTES;
      end
      if (header_skip > 0) begin
         header_skip--;
         return;
      end
      case (mode)
         MODE_PALETTE: begin
            shades[next_slot] = index_to_rgb565(code);
            next_slot = (next_slot == 2'd3) ? 2'd1 : next_slot + 2'd1;
            mode = MODE_IDLE;
            return;
         end
         MODE_EXTEND: begin
            grow_run(longint'(code));
            if (code == EXTEND_MORE) return;
         end
         default: begin
            run_index = code[7:6];
            run_total = 0;
            grow_run(longint'(code[5:0]));
            if (code[5:0] == 6'd0) begin
               mode = MODE_PALETTE;
               return;
            end
            if (code[5:0] == RUN_EXTEND_LEN) begin
               mode = MODE_EXTEND;
               return;
            end
         end
      endcase
      shade = shades[run_index];
      run.color = {shade[7:0], shade[15:8]};
      run.length = (run_total > 65535) ? 16'hffff : run_total[15:0];
      expected_runs.push_back(run);
      run_total = 0;
      mode = MODE_IDLE;
   endtask

   always @(posedge clock) begin
      pixel_run_type want;
      if (reset) begin
         restore_defaults();
         expected_runs.delete();
         errors = 0;
      end else begin
         if (req_valid && !req_stall) decode_code(req_code_byte, req_image_start);
         if (rsp_valid && !rsp_stall) begin
            if (expected_runs.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected run: color %h length %0d",
                           rsp_pixel_color, rsp_run_length);
            end else begin
               want = expected_runs.pop_front();
               if (want.color !== rsp_pixel_color || want.length !== rsp_run_length) begin
                  errors++;
                  if (errors <= 10)
                     $display("run mismatch: expected color %h length %0d, got color %h length %0d",
                              want.color, want.length, rsp_pixel_color, rsp_run_length);
               end
            end
         end
      end
      error_count <= errors;
      pending_runs <= expected_runs.size();
   end

endmodule

// ===== verif/tb_rle2bit_palette_image_decoder.sv =====
// Testbench top: drives compressed image bytes into the decoder and reports the verdict.
`timescale 1ns / 100ps

module tb_rle2bit_palette_image_decoder;
   import rle2_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_code_byte;
   logic        req_image_start;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_pixel_color;
   logic [15:0] rsp_run_length;
   int          error_count;
   int          pending_runs;

   int sender_idle_pct;
   int receiver_idle_pct;
   int random_items;

   // {image_start, code byte}
   logic [8:0] opening_codes [28] = '{
      9'h0c1, 9'h03e, 9'h041, 9'h0be,
      9'h000, 9'h000, 9'h040, 9'h0ff, 9'h080, 9'h0d8, 9'h0c0, 9'h0fb, 9'h000, 9'h0fc,
      9'h041, 9'h081, 9'h0c1,
      9'h07f, 9'h0ff, 9'h0ff, 9'h000,
      9'h0ff, 9'h0fe,
      9'h0bf, 9'h1c1, 9'h000, 9'h000, 9'h041
   };

   rle2bit_palette_image_decoder uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_byte   (req_code_byte),
      .req_image_start (req_image_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_run_length  (rsp_run_length)
   );

   rle2_run_checker run_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_byte   (req_code_byte),
      .req_image_start (req_image_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_run_length  (rsp_run_length),
      .error_count     (error_count),
      .pending_runs    (pending_runs)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb_rle2bit_palette_image_decoder: errors");
      $finish;
   end

   // result side back-pressure
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // returns at the edge where the request was taken
   task automatic send_code(input logic [7:0] code, input logic start);
      logic stalled;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_code_byte <= code;
      req_image_start <= start;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
   endtask

   task automatic send_header();
      send_code(8'($urandom_range(255)), 1'b1);
      repeat (HEADER_BYTES - 1)
         send_code(8'($urandom_range(255)), $urandom_range(15) == 0);
   endtask

   initial begin
      logic [1:0]  index;
      logic [7:0]  cube_index;
      int          more;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_code_byte <= 8'd0;
      req_image_start <= 1'b0;
      sender_idle_pct = 9;
      receiver_idle_pct = 63;
      random_items = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_codes[i]) send_code(opening_codes[i][7:0], opening_codes[i][8]);

      while (random_items < 1100) begin
         if (random_items >= 733) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end else if (random_items >= 367) begin
            sender_idle_pct = 63;
            receiver_idle_pct = 9;
         end
         index = 2'($urandom_range(3));
         case ($urandom_range(99)) inside
            [0:39]: begin
               send_code({index, 6'($urandom_range(62, 1))}, 1'b0);
               random_items += 1;
            end
            [40:54]: begin
               // extended run, now and then long enough to saturate
               more = ($urandom_range(29) == 0) ? 256 + int'($urandom_range(10))
                                                 : int'($urandom_range(3));
               send_code({index, RUN_EXTEND_LEN}, 1'b0);
               repeat (more) send_code(EXTEND_MORE, 1'b0);
               send_code(8'($urandom_range(254)), 1'b0);
               random_items += more + 2;
            end
            [55:74]: begin
               cube_index = ($urandom_range(3) == 0) ? 8'(208 + $urandom_range(47))
                                                      : 8'($urandom_range(255));
               send_code({index, 6'd0}, 1'b0);
               send_code(cube_index, 1'b0);
               random_items += 2;
            end
            [75:79]: begin
               send_header();
               random_items += HEADER_BYTES;
            end
            [80:89]: begin
               send_code(8'($urandom_range(255)), $urandom_range(15) == 0);
               random_items += 1;
            end
            default: begin
               // new image while a run or palette change may still be open
               send_code({index, ($urandom_range(1) != 0) ? RUN_EXTEND_LEN : 6'd0}, 1'b0);
               random_items += 1;
               if ($urandom_range(1) != 0) begin
                  send_code(EXTEND_MORE, 1'b0);
                  random_items += 1;
               end
               send_header();
               random_items += HEADER_BYTES;
            end
         endcase
      end
      req_valid <= 1'b0;

      while (pending_runs != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_runs == 0) begin
         $display("tb_rle2bit_palette_image_decoder: clean");
      end else begin
         $display("tb_rle2bit_palette_image_decoder: errors");
      end
      $finish;
   end

endmodule

// ===== rle2bit_palette_image_decoder.f =====
rtl/rle2_pkg.sv
rtl/rle2_core.sv
rtl/rle2bit_palette_image_decoder.sv
verif/rle2_run_checker.sv
verif/tb_rle2bit_palette_image_decoder.sv
